// File: hw/rtl/i2cmts_pkg.sv
`default_nettype none
package i2cmts_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF = 8;

  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int CHAN_W = 2;
  localparam int PHASE_W = 3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DONE = 1'b1;

  localparam logic [1:0] ADDR_NONE = 2'd0;
  localparam logic [1:0] ADDR_WRITE = 2'd1;
  localparam logic [1:0] ADDR_READ = 2'd2;

  localparam logic [1:0] STAT_ONGOING = 2'd0;
  localparam logic [1:0] STAT_SUCCESS = 2'd1;
  localparam logic [1:0] STAT_FAILURE = 2'd2;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE         = 3'd0,
    PH_WRITE_NEXT   = 3'd1,
    PH_WRITE_FINISH = 3'd2,
    PH_START_READ   = 3'd3,
    PH_READ_NEXT    = 3'd4,
    PH_READ_FINISH  = 3'd5
  } phase_t;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] channel;
    logic [ADDR_W-1:0] slave_address;
    logic [BYTE_W-1:0] write_count;
    logic [BYTE_W-1:0] read_count;
    logic [BYTE_W-1:0] next_tx_byte;
    logic              bus_error;
    logic [BYTE_W-1:0] received_byte;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic              issue_command;
    logic              cmd_start;
    logic              cmd_run;
    logic              cmd_stop;
    logic              cmd_ack;
    logic [1:0]        address_action;
    logic [ADDR_W-1:0] out_address;
    logic              put_valid;
    logic [BYTE_W-1:0] put_byte;
    logic              rx_valid;
    logic [1:0]        done_status;
  } out_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/i2c_master_transfer_sequencer_unit.sv
// I2C master write-then-read sequencer for NUM_CHANNELS bus controllers.
// Input channel (in_valid/in_ready/in_req): a start request loads a channel's
// target address and byte counts; a done request carries the controller's
// completion event (bus error, received byte) and moves that channel on.
// Result channel (out_valid/out_ready/out_rsp): exactly one result per request,
// in request order: command bits, address setup, transmit byte, rx delivery
// and done status for the addressed channel.
// Per-channel state sits in one synchronous memory indexed by channel. A
// request reads its entry at acceptance; the update stage updates it and
// writes it back as it advances; a write to the entry being read in the same
// cycle is forwarded. A request passes the update stage, then the output
// register; one request is accepted every cycle, including back-to-back
// requests on the same channel. When out_ready is low the result holds in
// the output register, the request behind it waits in the update stage, and
// in_ready drops. Reset (synchronous, rst_n low) clears per-entry valid flags,
// so every channel reads as idle with zero counts and address; no clearing
// pass. Channels at or above NUM_CHANNELS give all zeros except out_channel.
`default_nettype none
module i2c_master_transfer_sequencer_unit #(
  parameter int NUM_CHANNELS = i2cmts_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS = i2cmts_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire i2cmts_pkg::in_req_t  in_req,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output i2cmts_pkg::out_rsp_t      out_rsp
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = COUNT_BITS;
  localparam int LW = (CW > i2cmts_pkg::BYTE_W) ? CW : i2cmts_pkg::BYTE_W;
  localparam int RD_LSB = i2cmts_pkg::ADDR_W;
  localparam int WR_LSB = RD_LSB + CW;
  localparam int PH_LSB = WR_LSB + CW;
  localparam int EW = PH_LSB + i2cmts_pkg::PHASE_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [EW-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;

  logic                  s1_valid_r;
  i2cmts_pkg::in_req_t   s1_req_r;
  logic [EW-1:0]         rd_data_r;
  logic                  rd_vld_r;
  logic                  fwd_r;
  logic [EW-1:0]         fwd_data_r;
  logic                  out_valid_r;
  i2cmts_pkg::out_rsp_t  out_rsp_r;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  in_range_in;
  logic                  in_range_s1;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic [EW-1:0]         wr_data;
  logic [EW-1:0]         cur_ent;

  i2cmts_pkg::phase_t    cur_phase;
  i2cmts_pkg::phase_t    nxt_phase;
  i2cmts_pkg::phase_t    wb_phase;
  logic [CW-1:0]         cur_w;
  logic [CW-1:0]         cur_r;
  logic [i2cmts_pkg::ADDR_W-1:0] cur_addr;
  logic [CW-1:0]         nxt_w;
  logic [CW-1:0]         nxt_r;
  logic [i2cmts_pkg::ADDR_W-1:0] nxt_addr;
  logic [LW-1:0]         wc_wide;
  logic [LW-1:0]         rc_wide;
  logic [CW-1:0]         w_sat;
  logic [CW-1:0]         r_sat;
  logic                  is_start;
  logic [CW-1:0]         w_src;
  logic [CW-1:0]         r_src;
  logic [CW-1:0]         w_dec;
  logic [CW-1:0]         r_dec;
  logic                  r_src_one;
  i2cmts_pkg::out_rsp_t  rsp;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire = in_valid && in_ready;

  assign in_range_in = (32'(in_req.channel) < 32'(NUM_CHANNELS));
  assign in_range_s1 = (32'(s1_req_r.channel) < 32'(NUM_CHANNELS));
  assign rd_addr = AW'(in_req.channel);
  assign wr_addr = AW'(s1_req_r.channel);
  assign wr_en = s1_adv && in_range_s1;
  assign wr_data = {nxt_phase, nxt_w, nxt_r, nxt_addr};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_range_in) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_r <= in_range_in && vld_r[rd_addr];
        fwd_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

  assign cur_ent = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : '0);
  assign cur_phase = i2cmts_pkg::phase_t'(cur_ent[PH_LSB +: i2cmts_pkg::PHASE_W]);
  assign cur_w = cur_ent[WR_LSB +: CW];
  assign cur_r = cur_ent[RD_LSB +: CW];
  assign cur_addr = cur_ent[0 +: i2cmts_pkg::ADDR_W];

  assign wc_wide = LW'(s1_req_r.write_count);
  assign rc_wide = LW'(s1_req_r.read_count);
  assign w_sat = (wc_wide > LW'(CNT_MAX)) ? CNT_MAX : CW'(wc_wide);
  assign r_sat = (rc_wide > LW'(CNT_MAX)) ? CNT_MAX : CW'(rc_wide);

  assign is_start = (s1_req_r.operation == i2cmts_pkg::OP_START);
  assign w_src = is_start ? w_sat : cur_w;
  assign r_src = is_start ? r_sat : cur_r;
  assign w_dec = (w_src == '0) ? '0 : w_src - CNT_ONE;
  assign r_dec = (cur_r == '0) ? '0 : cur_r - CNT_ONE;
  assign r_src_one = (r_src == CNT_ONE);
  assign wb_phase = (w_dec != '0) ? i2cmts_pkg::PH_WRITE_NEXT :
                    (r_src == '0) ? i2cmts_pkg::PH_WRITE_FINISH :
                                    i2cmts_pkg::PH_START_READ;

  // next state of the entry
  always_comb begin
    nxt_phase = cur_phase;
    nxt_w = cur_w;
    nxt_r = cur_r;
    nxt_addr = cur_addr;
    if (is_start) begin
      nxt_addr = s1_req_r.slave_address;
      nxt_w = w_sat;
      nxt_r = r_sat;
      if (w_sat != '0) begin
        nxt_w = w_dec;
        nxt_phase = wb_phase;
      end else if (r_sat != '0) begin
        nxt_phase = r_src_one ? i2cmts_pkg::PH_READ_FINISH : i2cmts_pkg::PH_READ_NEXT;
      end
    end else if (s1_req_r.bus_error) begin
      nxt_phase = i2cmts_pkg::PH_IDLE;
    end else begin
      case (cur_phase)
        i2cmts_pkg::PH_WRITE_NEXT: begin
          nxt_w = w_dec;
          nxt_phase = wb_phase;
        end
        i2cmts_pkg::PH_WRITE_FINISH: begin
          nxt_phase = i2cmts_pkg::PH_IDLE;
        end
        i2cmts_pkg::PH_START_READ: begin
          nxt_phase = r_src_one ? i2cmts_pkg::PH_READ_FINISH : i2cmts_pkg::PH_READ_NEXT;
        end
        i2cmts_pkg::PH_READ_NEXT: begin
          nxt_r = r_dec;
          if (r_dec == CNT_ONE) begin
            nxt_phase = i2cmts_pkg::PH_READ_FINISH;
          end
        end
        i2cmts_pkg::PH_READ_FINISH: begin
          nxt_r = r_dec;
          nxt_phase = i2cmts_pkg::PH_IDLE;
        end
        default: begin
          nxt_phase = i2cmts_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result of the step
  always_comb begin
    rsp = '0;
    rsp.out_channel = s1_req_r.channel;
    if (in_range_s1) begin
      if (is_start) begin
        if (w_sat != '0) begin
          rsp.address_action = i2cmts_pkg::ADDR_WRITE;
          rsp.out_address = s1_req_r.slave_address;
          rsp.put_valid = 1'b1;
          rsp.put_byte = s1_req_r.next_tx_byte;
          rsp.issue_command = 1'b1;
          rsp.cmd_start = 1'b1;
          rsp.cmd_run = 1'b1;
          rsp.cmd_stop = (wb_phase == i2cmts_pkg::PH_WRITE_FINISH);
        end else if (r_sat != '0) begin
          rsp.address_action = i2cmts_pkg::ADDR_READ;
          rsp.out_address = s1_req_r.slave_address;
          rsp.issue_command = 1'b1;
          rsp.cmd_start = 1'b1;
          rsp.cmd_run = 1'b1;
          rsp.cmd_ack = !r_src_one;
        end
      end else if (s1_req_r.bus_error) begin
        rsp.done_status = i2cmts_pkg::STAT_FAILURE;
      end else begin
        case (cur_phase)
          i2cmts_pkg::PH_WRITE_NEXT: begin
            rsp.put_valid = 1'b1;
            rsp.put_byte = s1_req_r.next_tx_byte;
            rsp.issue_command = 1'b1;
            rsp.cmd_run = 1'b1;
            rsp.cmd_stop = (wb_phase == i2cmts_pkg::PH_WRITE_FINISH);
          end
          i2cmts_pkg::PH_WRITE_FINISH: begin
            rsp.done_status = i2cmts_pkg::STAT_SUCCESS;
          end
          i2cmts_pkg::PH_START_READ: begin
            rsp.address_action = i2cmts_pkg::ADDR_READ;
            rsp.out_address = cur_addr;
            rsp.issue_command = 1'b1;
            rsp.cmd_start = 1'b1;
            rsp.cmd_run = 1'b1;
            rsp.cmd_ack = !r_src_one;
          end
          i2cmts_pkg::PH_READ_NEXT: begin
            rsp.rx_valid = 1'b1;
            rsp.issue_command = 1'b1;
            rsp.cmd_run = 1'b1;
            rsp.cmd_ack = (r_dec != CNT_ONE);
          end
          i2cmts_pkg::PH_READ_FINISH: begin
            rsp.rx_valid = 1'b1;
            rsp.issue_command = 1'b1;
            rsp.cmd_stop = 1'b1;
            rsp.done_status = i2cmts_pkg::STAT_SUCCESS;
          end
          default: begin
            rsp.done_status = i2cmts_pkg::STAT_ONGOING;
          end
        endcase
      end
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("request stalled with empty output register");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> $stable(rd_data_r) && $stable(fwd_r))
    else $error("entry read data changed under a stalled request");

  a_cmd_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp_r.issue_command |->
      !(out_rsp_r.cmd_start || out_rsp_r.cmd_run || out_rsp_r.cmd_stop || out_rsp_r.cmd_ack))
    else $error("command bits without a command");

  a_addr_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.address_action != i2cmts_pkg::ADDR_NONE |->
      out_rsp_r.cmd_start)
    else $error("address setup without start condition");

  a_done_no_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.done_status != i2cmts_pkg::STAT_ONGOING |->
      !out_rsp_r.put_valid)
    else $error("transmit byte loaded on a finished transaction");

endmodule
`default_nettype wire
